FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/llpa_pkg.sv
// ----------------------------------------------------------------------------
// llpa_pkg
// Shared types and constants for the least-loaded port allocator.
// ----------------------------------------------------------------------------
package llpa_pkg;

	localparam int DEF_NUM_PORTS   = 16;
	localparam int DEF_GROUP_CODES = 256;
	localparam int DEF_COUNT_WIDTH = 8;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_WRITE   = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_PORT      = 2'd1,
		ST_IDLE_RELEASE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic finish;
	} llpa_cmd_t;

	typedef struct packed {
		logic scan_last;
	} llpa_stat_t;

endpackage

FILE: rtl/llpa_req_if.sv
// ----------------------------------------------------------------------------
// llpa_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface llpa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  group_code;
	logic [3:0]  port_index;
	logic [15:0] port_mask;

	modport source (output valid, output req_type, output group_code,
		output port_index, output port_mask, input ready);
	modport sink (input valid, input req_type, input group_code,
		input port_index, input port_mask, output ready);
endinterface

FILE: rtl/llpa_rsp_if.sv
// ----------------------------------------------------------------------------
// llpa_rsp_if
// Response channel: valid/ready handshake with the allocation result.
// ----------------------------------------------------------------------------
interface llpa_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] chosen_port;
	logic [1:0] status;

	modport source (output valid, output chosen_port, output status, input ready);
	modport sink (input valid, input chosen_port, input status, output ready);
endinterface

FILE: rtl/llpa_ctrl.sv
// ----------------------------------------------------------------------------
// llpa_ctrl
// Controller: sequences accept, counter scan and result write-back.
// ----------------------------------------------------------------------------
module llpa_ctrl
	import llpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_req_type,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	output llpa_cmd_t  cmd,
	input  llpa_stat_t stat
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_nxt = (in_req_type == REQ_ALLOC) ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				// The result register must be empty or draining this cycle.
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/llpa_dp.sv
// ----------------------------------------------------------------------------
// llpa_dp
// Datapath: support table memory, occupancy counters, minimum scan, result.
// ----------------------------------------------------------------------------
module llpa_dp
	import llpa_pkg::*;
#(
	parameter int NUM_PORTS   = DEF_NUM_PORTS,
	parameter int GROUP_CODES = DEF_GROUP_CODES,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  llpa_cmd_t   cmd,
	output llpa_stat_t  stat,
	input  logic [1:0]  req_type,
	input  logic [7:0]  group_code,
	input  logic [3:0]  port_index,
	input  logic [15:0] port_mask,
	output logic [3:0]  chosen_port,
	output logic [1:0]  status
);

	localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int GW = $clog2(GROUP_CODES);

	logic [NUM_PORTS-1:0]   tbl_mem [GROUP_CODES];
	logic [GROUP_CODES-1:0] tbl_vld_q;
	logic [NUM_PORTS-1:0]   rd_data_q;
	logic                   rd_vld_q;

	logic [COUNT_WIDTH-1:0] cnt_q [NUM_PORTS];

	logic [1:0]             kind_q;
	logic [PW-1:0]          rel_q;
	logic                   rel_ok_q;
	logic [PW-1:0]          scan_idx_q;
	logic                   found_q;
	logic [COUNT_WIDTH-1:0] best_q;
	logic [PW-1:0]          pick_q;
	logic [3:0]             chosen_q;
	logic [1:0]             status_q;

	logic                   grp_ok;
	logic [GW-1:0]          grp_idx;
	logic                   tbl_we;
	logic [NUM_PORTS-1:0]   avail;
	logic [PW-1:0]          cnt_addr;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic                   cnt_we;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic [3:0]             res_port;
	logic [1:0]             res_status;

	assign grp_ok  = {1'b0, group_code} < 9'(GROUP_CODES);
	assign grp_idx = group_code[GW-1:0];
	assign tbl_we  = cmd.accept && (req_type == REQ_WRITE) && grp_ok;

	// Support table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[grp_idx] <= port_mask[NUM_PORTS-1:0];
		end
		if (cmd.accept) begin
			rd_data_q <= tbl_mem[grp_idx];
		end
	end

	// An entry never written since reset reads as an empty mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else if (cmd.accept) begin
			if (tbl_we) begin
				tbl_vld_q[grp_idx] <= 1'b1;
			end
			rd_vld_q <= tbl_vld_q[grp_idx] && grp_ok;
		end
	end

	assign avail = rd_vld_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q   <= req_type;
			rel_q    <= port_index[PW-1:0];
			rel_ok_q <= {1'b0, port_index} < 5'(NUM_PORTS);
		end
	end

	always_comb begin
		if (cmd.scan_step) begin
			cnt_addr = scan_idx_q;
		end else if (kind_q == REQ_ALLOC) begin
			cnt_addr = pick_q;
		end else begin
			cnt_addr = rel_q;
		end
	end

	assign cnt_rd         = cnt_q[cnt_addr];
	assign stat.scan_last = (scan_idx_q == PW'(NUM_PORTS - 1));

	// One port per cycle; a strict less-than keeps the lowest index on a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			found_q    <= 1'b0;
		end else if (cmd.accept) begin
			scan_idx_q <= '0;
			found_q    <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + PW'(1);
			if (avail[scan_idx_q] && (!found_q || (cnt_rd < best_q))) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && avail[scan_idx_q] && (!found_q || (cnt_rd < best_q))) begin
			best_q <= cnt_rd;
			pick_q <= scan_idx_q;
		end
	end

	always_comb begin
		res_port   = '0;
		res_status = ST_OK;
		cnt_we     = 1'b0;
		cnt_wdata  = cnt_rd;
		case (kind_q)
			REQ_ALLOC: begin
				if (found_q) begin
					res_port = 4'(pick_q);
					if (cnt_rd != '1) begin
						cnt_we    = 1'b1;
						cnt_wdata = cnt_rd + COUNT_WIDTH'(1);
					end
				end else begin
					res_status = ST_NO_PORT;
				end
			end
			REQ_RELEASE: begin
				if (rel_ok_q) begin
					if (cnt_rd == '0) begin
						res_status = ST_IDLE_RELEASE;
					end else begin
						cnt_we    = 1'b1;
						cnt_wdata = cnt_rd - COUNT_WIDTH'(1);
					end
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.finish && cnt_we) begin
			cnt_q[cnt_addr] <= cnt_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			chosen_q <= res_port;
			status_q <= res_status;
		end
	end

	assign chosen_port = chosen_q;
	assign status      = status_q;

endmodule

FILE: rtl/least_loaded_port_allocator.sv
// ----------------------------------------------------------------------------
// least_loaded_port_allocator
// Picks the least occupied execution port that supports an instruction group.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel (valid/ready). An allocate returns the
//   supporting port with the lowest occupancy and bumps its count; a release
//   decrements a port's count; a write fills one support table entry.
//   Every request yields exactly one transaction on the rsp channel.
// Allocate scan:
//   An allocate walks the occupancy counters one port per cycle; the block
//   accepts no new request until the result is written back. Release and
//   write requests skip the scan. The serial counter scan sets the allocate
//   rate.
// Reset:
//   arst_n clears all occupancy counts and marks every support table entry
//   empty at once; the block accepts a request in the first cycle after reset.
// Stall:
//   The result sits in an output register. A new request is accepted while it
//   waits; the next result is held back until the receiver takes the first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module least_loaded_port_allocator
	import llpa_pkg::*;
#(
	parameter int NUM_PORTS   = DEF_NUM_PORTS,
	parameter int GROUP_CODES = DEF_GROUP_CODES,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	llpa_req_if.sink  req,
	llpa_rsp_if.source rsp
);

	llpa_cmd_t  cmd;
	llpa_stat_t stat;

	llpa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.cmd         (cmd),
		.stat        (stat)
	);

	llpa_dp #(
		.NUM_PORTS   (NUM_PORTS),
		.GROUP_CODES (GROUP_CODES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req.req_type),
		.group_code  (req.group_code),
		.port_index  (req.port_index),
		.port_mask   (req.port_mask),
		.chosen_port (rsp.chosen_port),
		.status      (rsp.status)
	);

	// A result is only written into a free or draining output register.
	`ASSERT_IMPL(a_fin_no_overwrite, clk, arst_n, cmd.finish, !rsp.valid || rsp.ready)
	// In the cycle after an accepted transaction the block is busy.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	// The counter scan never overlaps acceptance or write-back.
	`ASSERT_IMPL(a_scan_exclusive, clk, arst_n, cmd.scan_step, !req.ready && !cmd.finish)

endmodule
